>>> src/display_frame_builder_defines.svh
// Assertion macros used by the display frame builder datapath.
`ifndef DISPLAY_FRAME_BUILDER_DEFINES_SVH
`define DISPLAY_FRAME_BUILDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DFB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("display frame builder: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("display frame builder: next-cycle check failed");

`endif

>>> src/dfb_pkg.sv
// Types and constants of the display frame builder.
package dfb_pkg;

  localparam int unsigned FRAME_LEN = 13;
  localparam int unsigned IDX_W     = 4;
  localparam logic [IDX_W-1:0] LAST_IDX = 4'd13;

  // Frame byte positions
  localparam logic [IDX_W-1:0] MODE_POS  = 4'd4;
  localparam logic [IDX_W-1:0] BATH_POS  = 4'd6;
  localparam logic [IDX_W-1:0] BATL_POS  = 4'd7;
  localparam logic [IDX_W-1:0] SPDH_POS  = 4'd8;
  localparam logic [IDX_W-1:0] SPDL_POS  = 4'd9;
  localparam logic [IDX_W-1:0] LED0_POS  = 4'd10;
  localparam logic [IDX_W-1:0] LED1_POS  = 4'd11;
  localparam logic [IDX_W-1:0] LED2_POS  = 4'd12;

  localparam logic [7:0] FRAME_INIT [FRAME_LEN] = '{
    8'h02, 8'h0E, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
    8'h08, 8'hF0, 8'hF0, 8'h00, 8'h00
  };

  // Byte patterns
  localparam logic [7:0] MODE_BLANK = 8'h00;
  localparam logic [7:0] PAT_BLANK  = 8'hF0;
  localparam logic [7:0] PAT_LED_ON = 8'hF1;
  localparam logic [7:0] PAT_LIT    = 8'h80;
  localparam logic [7:0] PAT_CLEAR  = 8'h00;

  // LED request codes
  localparam logic [1:0] LED_OFF   = 2'd0;
  localparam logic [1:0] LED_ON    = 2'd1;
  localparam logic [1:0] LED_BLINK = 2'd2;
  localparam logic [1:0] LED_NONE  = 2'd3;

  // Speed code: floor((SPEED_NUM + d) / (2d)), d = 2t + 1
  localparam int unsigned NUM_W     = 17;
  localparam int unsigned DEN_W     = 12;
  localparam int unsigned QUOT_W    = 16;
  localparam logic [NUM_W-1:0]  SPEED_NUM = 17'd89440;
  localparam logic [QUOT_W-1:0] SPEED_MAX = 16'd44720;
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

  typedef enum logic [2:0] {
    REQ_MODE    = 3'd0,
    REQ_LED     = 3'd1,
    REQ_BATTERY = 3'd2,
    REQ_SPEED   = 3'd3,
    REQ_SEND    = 3'd4
  } req_e;

  // Controller to datapath
  typedef struct packed {
    logic             apply;
    req_e             req;
    logic             div_start;
    logic             div_store;
    logic             clear_sum;
    logic             emit;
    logic [IDX_W-1:0] idx;
  } dfb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } dfb_stat_t;

endpackage

>>> src/dfb_divider.sv
// Restoring divider, one quotient bit per cycle, for the speed code.
module dfb_divider import dfb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic              done_o,
  output logic [QUOT_W-1:0] quot_o
);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Shift in the next dividend bit and try to subtract
  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    fits  = trial >= {1'b0, den_q};
    rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    num_d = {num_q[NUM_W-2:0], fits};
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Advance the operands
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q[QUOT_W-1:0];

endmodule

>>> src/dfb_datapath.sv
// Frame store, speed divider, checksum and output register.
`include "display_frame_builder_defines.svh"

module dfb_datapath import dfb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dfb_cmd_t    cmd_i,
  output dfb_stat_t   stat_o,
  input  logic [7:0]  mode_value_i,
  input  logic [1:0]  led_mode_i,
  input  logic [15:0] battery_value_i,
  input  logic [9:0]  speed_tenths_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic        last_byte_o
);

  logic [7:0]        store_q [FRAME_LEN];
  logic [7:0]        csum_q;
  logic              out_valid_q;
  logic [7:0]        byte_q;
  logic              last_q;
  logic [10:0]       d_val;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_done;
  logic [QUOT_W-1:0] quot;
  logic              is_last;
  logic [7:0]        emit_byte;

  // Build divider operands: d = 2t + 1
  assign d_val   = {speed_tenths_i, 1'b1};
  assign div_num = SPEED_NUM + NUM_W'(d_val);
  assign div_den = {d_val, 1'b0};

  dfb_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Apply field writes to the frame store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAME_LEN; i++) begin
        store_q[i] <= FRAME_INIT[i];
      end
    end else begin
      if (cmd_i.apply) begin
        case (cmd_i.req)
          REQ_MODE: begin
            store_q[MODE_POS] <= mode_value_i;
            if (mode_value_i == MODE_BLANK) begin
              store_q[LED0_POS] <= PAT_BLANK;
            end
          end
          REQ_LED: begin
            case (led_mode_i)
              LED_OFF: begin
                store_q[LED0_POS] <= PAT_CLEAR;
                store_q[LED1_POS] <= PAT_CLEAR;
                store_q[LED2_POS] <= PAT_CLEAR;
              end
              LED_ON: begin
                store_q[LED0_POS] <= PAT_LED_ON;
                store_q[LED1_POS] <= PAT_LIT;
                store_q[LED2_POS] <= PAT_CLEAR;
              end
              LED_BLINK: store_q[LED2_POS] <= PAT_LIT;
              default: ;
            endcase
          end
          REQ_BATTERY: begin
            store_q[BATH_POS] <= battery_value_i[15:8];
            store_q[BATL_POS] <= battery_value_i[7:0];
          end
          default: ;
        endcase
      end
      if (cmd_i.div_store) begin
        store_q[SPDH_POS] <= quot[15:8];
        store_q[SPDL_POS] <= quot[7:0];
      end
    end
  end

  // Select the byte for this beat
  assign is_last   = cmd_i.idx == LAST_IDX;
  assign emit_byte = is_last ? csum_q : store_q[cmd_i.idx];

  // Accumulate the checksum over the frame bytes
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_sum) begin
      csum_q <= '0;
    end else if (cmd_i.emit && !is_last) begin
      csum_q <= csum_q ^ emit_byte;
    end
  end

  // Hold the outgoing beat until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      byte_q <= emit_byte;
      last_q <= is_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_byte_o    = byte_q;
  assign last_byte_o     = last_q;
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  `DFB_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, cmd_i.emit, !out_valid_q || !out_stall_i)
  `DFB_ASSERT_NEXT(a_last_flag, clk_i, rst_ni, cmd_i.emit && is_last, out_valid_o && last_byte_o)
  `DFB_ASSERT_IMPL(a_speed_range, clk_i, rst_ni, div_done, quot <= SPEED_MAX)

endmodule

>>> src/dfb_ctrl.sv
// Request sequencer of the display frame builder.
module dfb_ctrl import dfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] req_type_i,
  input  dfb_stat_t  stat_i,
  output dfb_cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEND
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             accept;
  req_e             req;

  assign req        = req_e'(req_type_i);
  assign in_stall_o = state_q != ST_IDLE;
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // Decode commands and next state
  always_comb begin
    state_d         = state_q;
    idx_d           = idx_q;
    cmd_o           = '0;
    cmd_o.req       = req;
    cmd_o.idx       = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req)
            REQ_SPEED: begin
              cmd_o.div_start = 1'b1;
              state_d         = ST_DIV;
            end
            REQ_SEND: begin
              cmd_o.clear_sum = 1'b1;
              idx_d           = '0;
              state_d         = ST_SEND;
            end
            default: cmd_o.apply = 1'b1;
          endcase
        end
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.div_store = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_SEND: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (idx_q == LAST_IDX) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and beat index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

>>> src/display_frame_builder.sv
// Display frame builder: 13-byte frame store with checksummed frame output.
//
// Input channel: one request per beat (in_valid_i / in_stall_o), fields
// req_type_i, mode_value_i, led_mode_i, battery_value_i, speed_tenths_i.
// Set-mode, set-LED and set-battery requests take effect at the accepting
// edge; the next request may follow in the next cycle.
// A speed request runs a restoring divider, one quotient bit per cycle,
// and holds in_stall_o high until the quotient is stored in the frame.
// A send request emits 14 beats on the output channel (out_valid_o /
// out_stall_i): frame bytes 0 to 12, then their XOR checksum with
// last_byte_o set. With no stall one byte follows each cycle, and the
// next request is taken once the checksum beat is emitted. The single
// output register sets the pace; a stalled receiver holds the current
// beat and pauses emission.
// Reset loads the frame store with mode 01 and speed code 08F0 and
// empties the output register; requests are taken right after reset.
module display_frame_builder import dfb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  mode_value_i,
  input  logic [1:0]  led_mode_i,
  input  logic [15:0] battery_value_i,
  input  logic [9:0]  speed_tenths_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic        last_byte_o
);

  dfb_cmd_t  cmd;
  dfb_stat_t stat;

  dfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dfb_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .mode_value_i    (mode_value_i),
    .led_mode_i      (led_mode_i),
    .battery_value_i (battery_value_i),
    .speed_tenths_i  (speed_tenths_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_byte_o    (frame_byte_o),
    .last_byte_o     (last_byte_o)
  );

endmodule
